// ===== src/packed_pixel_palette_expander_assert.svh =====
// assertion macros shared by the palette expander rtl
`ifndef PACKED_PIXEL_PALETTE_EXPANDER_ASSERT_SVH
`define PACKED_PIXEL_PALETTE_EXPANDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PPX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PPX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ppx_pkg.sv =====
// shared types and constants of the palette expander
`timescale 1ns / 1ps

package ppx_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int PAL_DW      = 32;
	localparam int LEN_W       = 12;
	localparam logic [LEN_W-1:0] MAX_LINE_PIXELS = 12'd4095;

	typedef enum logic [1:0] {
		OP_PAL_WR = 2'd0,
		OP_LINE   = 2'd1,
		OP_DATA   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// register indexes on the apb port
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_FILL   = 1'b1;

	// one raw pixel handed from the unpacker to the lookup stage
	typedef struct packed {
		logic       valid;
		logic [7:0] value;
		logic       last;
	} emit_t;

endpackage

// ===== src/ppx_ram.sv =====
// generic single-write, registered-read ram
`timescale 1ns / 1ps

module ppx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read and a write to one entry in the same cycle return the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ppx_unpack.sv =====
// byte unpacker: walks the bit position and pixel count, one pixel per cycle while advance is high
`timescale 1ns / 1ps

module ppx_unpack (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              size_code,
	input  logic                    accept,
	input  ppx_pkg::op_t            op,
	input  logic [2:0]              start_phase,
	input  logic [ppx_pkg::LEN_W-1:0] line_length,
	input  logic [7:0]              data_byte,
	input  logic                    advance,
	output logic                    ready,
	output ppx_pkg::emit_t          emit
);

	logic                      busy_q, busy_d;
	logic [2:0]                pos_q, pos_d;
	logic [ppx_pkg::LEN_W-1:0] left_q, left_d;
	logic [7:0]                byte_q;
	logic [3:0]                bpp;
	logic [7:0]                mask;
	logic [7:0]                shifted;
	logic                      wrap;
	logic                      last;
	logic                      step;
	logic [2:0]                first_pos;
	logic [2:0]                step_pos;
	logic [ppx_pkg::LEN_W-1:0] step_left;

	assign bpp     = 4'(4'd1 << size_code);
	assign mask    = 8'((9'd1 << bpp) - 9'd1);
	assign shifted = byte_q >> pos_q;
	assign wrap    = {1'b0, pos_q} < bpp;
	assign last    = (left_q == ppx_pkg::LEN_W'(1));
	assign step    = busy_q && advance;

	always_comb begin
		case (size_code)
			2'd0:    first_pos = 3'd7 - start_phase;
			2'd1:    first_pos = 3'd6 - {start_phase[1:0], 1'b0};
			2'd2:    first_pos = 3'd4 - {start_phase[0], 2'b00};
			default: first_pos = 3'd0;
		endcase
	end

	assign step_pos  = wrap ? 3'(4'd8 - bpp) : (pos_q - bpp[2:0]);
	assign step_left = left_q - ppx_pkg::LEN_W'(1);

	// free now, or giving out the final pixel of the byte or of the line this cycle
	assign ready = !busy_q || (step && (wrap || last));

	always_comb begin
		busy_d = busy_q;
		pos_d  = pos_q;
		left_d = left_q;
		if (step) begin
			pos_d  = step_pos;
			left_d = step_left;
			if (wrap || last) begin
				busy_d = 1'b0;
			end
		end
		if (accept) begin
			case (op)
				ppx_pkg::OP_LINE: begin
					pos_d  = first_pos;
					left_d = (line_length > ppx_pkg::MAX_LINE_PIXELS) ?
						ppx_pkg::MAX_LINE_PIXELS : line_length;
				end
				ppx_pkg::OP_DATA: begin
					busy_d = (left_d != '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			left_q <= '0;
		end else begin
			busy_q <= busy_d;
			pos_q  <= pos_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == ppx_pkg::OP_DATA) begin
			byte_q <= data_byte;
		end
	end

	assign emit.valid = step;
	assign emit.value = shifted & mask;
	assign emit.last  = last;

endmodule

// ===== src/packed_pixel_palette_expander.sv =====
// top level of the packed pixel expander with color lookup
`timescale 1ns / 1ps

// Expands packed 1, 2, 4 or 8 bit pixels, most significant first, into a 24-bit
// color and an 8-bit alpha. Word op 0 writes a palette entry, op 1 opens a line
// (start phase and pixel count), op 2 brings one data byte, and op 3 is ignored.
// Ops 0, 1 and 3 never make the unpacker busy; a data byte keeps it busy until
// the last pixel it gives out (1 to 8, or none when no line is open), and the
// unpacker issues one palette read per cycle while the output is not stalled.
// The next word is taken in the cycle the final pixel of a byte or line leaves
// the unpacker, so a stream of bytes gives one pixel every cycle while the output
// is not stalled. The first pixel of a byte passes unpack, palette read and the
// output register before it is offered. A stalled output holds the whole
// pixel path; palette writes and line starts are still taken while the unpacker
// is free. Palette entries read before they are written give undefined color
// and alpha; there is no clearing pass after reset. color_format and fill_color
// sit at byte addresses 0 and 4 and are meant to be written only while idle.

`include "packed_pixel_palette_expander_assert.svh"

module packed_pixel_palette_expander (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_rgb,
	input  logic [7:0]  palette_alpha,
	input  logic [2:0]  start_phase,
	input  logic [11:0] line_length,
	input  logic [7:0]  data_byte,
	// output words, one per pixel
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output logic [23:0] pixel_color,
	output logic [7:0]  pixel_alpha,
	output logic        last_of_line
);

	// configuration registers
	logic [2:0]  color_format_q;
	logic [23:0] fill_color_q;
	logic        cfg_wr;

	// pipeline control
	logic           accept;
	logic           advance;
	ppx_pkg::op_t   op_in;
	ppx_pkg::emit_t emit;

	// palette port
	logic                      pal_we;
	logic [ppx_pkg::PAL_DW-1:0] pal_rdata;
	logic                      rd_in_range;

	// lookup stage
	logic       s1_valid;
	logic       s1_indexed;
	logic       s1_in_range;
	logic [7:0] s1_alpha;
	logic       s1_last;
	logic [7:0] alpha_expanded;

	// output register
	logic        pixel_valid_q;
	logic [23:0] pixel_color_q;
	logic [7:0]  pixel_alpha_q;
	logic        last_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_format_q <= '0;
			fill_color_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				ppx_pkg::REG_FORMAT: color_format_q <= pwdata[2:0];
				ppx_pkg::REG_FILL:   fill_color_q   <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ppx_pkg::REG_FORMAT: prdata = {29'd0, color_format_q};
			ppx_pkg::REG_FILL:   prdata = {8'd0, fill_color_q};
			default:             prdata = '0;
		endcase
	end

	// ---------------- input side ----------------
	assign op_in   = ppx_pkg::op_t'(op);
	assign accept  = item_valid && item_ready;
	// the whole pixel path moves when the output register is free or drained
	assign advance = !pixel_valid_q || pixel_ready;

	ppx_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.size_code   (color_format_q[1:0]),
		.accept      (accept),
		.op          (op_in),
		.start_phase (start_phase),
		.line_length (line_length),
		.data_byte   (data_byte),
		.advance     (advance),
		.ready       (item_ready),
		.emit        (emit)
	);

	// ---------------- palette ----------------
	// writes beyond the palette are dropped
	assign pal_we = accept && (op_in == ppx_pkg::OP_PAL_WR) &&
		({1'b0, palette_index} < 9'(ppx_pkg::PAL_ENTRIES));
	assign rd_in_range = {1'b0, emit.value} < 9'(ppx_pkg::PAL_ENTRIES);

	// read data stays put while the path is stalled, so it lines up with s1
	ppx_ram #(
		.WIDTH (ppx_pkg::PAL_DW),
		.DEPTH (ppx_pkg::PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[ppx_pkg::PAL_AW-1:0]),
		.wdata ({palette_alpha, palette_rgb}),
		.re    (advance),
		.raddr (emit.value[ppx_pkg::PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	// ---------------- alpha expansion for alpha formats ----------------
	// bit replication equals multiplying by 255, 85, 17 or 1
	always_comb begin
		case (color_format_q[1:0])
			2'd0:    alpha_expanded = {8{emit.value[0]}};
			2'd1:    alpha_expanded = {4{emit.value[1:0]}};
			2'd2:    alpha_expanded = {2{emit.value[3:0]}};
			default: alpha_expanded = emit.value;
		endcase
	end

	// ---------------- lookup stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (advance) begin
			s1_valid <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s1_indexed  <= color_format_q[2];
			s1_in_range <= rd_in_range;
			s1_alpha    <= alpha_expanded;
			s1_last     <= emit.last;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (advance) begin
			pixel_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_q <= s1_last;
			if (!s1_indexed) begin
				pixel_color_q <= fill_color_q;
				pixel_alpha_q <= s1_alpha;
			end else if (s1_in_range) begin
				pixel_color_q <= pal_rdata[23:0];
				pixel_alpha_q <= pal_rdata[31:24];
			end else begin
				pixel_color_q <= '0;
				pixel_alpha_q <= '0;
			end
		end
	end

	assign pixel_valid  = pixel_valid_q;
	assign pixel_color  = pixel_color_q;
	assign pixel_alpha  = pixel_alpha_q;
	assign last_of_line = last_q;

	// ---------------- checks ----------------
	`PPX_ASSERT_IMP(a_no_emit_on_stall, clk, arst_n, !advance, !emit.valid, "unpacker stepped during an output stall")
	`PPX_ASSERT_NXT(a_s1_holds_on_stall, clk, arst_n, s1_valid && !advance, s1_valid && $stable(s1_last) && $stable(pal_rdata), "lookup stage lost its pixel during a stall")
	`PPX_ASSERT_IMP(a_out_from_s1, clk, arst_n, $rose(pixel_valid_q), $past(s1_valid), "output word appeared with no pixel in the lookup stage")
	`PPX_ASSERT_NXT(a_last_ends_line, clk, arst_n, emit.valid && emit.last && !accept, !emit.valid, "unpacker kept going past the final pixel of a line")

endmodule

// ===== bench/tb.sv =====
// self-checking testbench of the packed pixel palette expander
`timescale 1ns / 1ps

module tb;
	import ppx_pkg::*;

	localparam int HALF_NS      = 4;
	localparam int DRAIN_CYCLES = 16;      // pixel path is three stages plus up to eight pixels
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASES       = 8;       // one phase per color format
	localparam int PHASE_WORDS  = 16;

	// one input word, every field of the port
	typedef struct packed {
		op_t         op;
		logic [7:0]  pal_index;
		logic [23:0] pal_rgb;
		logic [7:0]  pal_alpha;
		logic [2:0]  phase;
		logic [11:0] length;
		logic [7:0]  data;
	} word_t;

	// one output word, a decoded pixel
	typedef struct packed {
		logic [23:0] color;
		logic [7:0]  alpha;
		logic        eol;
	} pixel_t;

	// a row of the directed table: a register write or a word, with an
	// optional pixel typed in by hand
	typedef struct {
		bit          is_cfg;
		logic        cfg_reg;
		logic [31:0] cfg_val;
		word_t       w;
		bit          fixed;
		pixel_t      want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  op = '0;
	logic [7:0]  palette_index = '0;
	logic [23:0] palette_rgb = '0;
	logic [7:0]  palette_alpha = '0;
	logic [2:0]  start_phase = '0;
	logic [11:0] line_length = '0;
	logic [7:0]  data_byte = '0;
	logic        pixel_valid;
	logic        pixel_ready = 1'b0;
	logic [23:0] pixel_color;
	logic [7:0]  pixel_alpha;
	logic        last_of_line;

	packed_pixel_palette_expander DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.op            (op),
		.palette_index (palette_index),
		.palette_rgb   (palette_rgb),
		.palette_alpha (palette_alpha),
		.start_phase   (start_phase),
		.line_length   (line_length),
		.data_byte     (data_byte),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel_color   (pixel_color),
		.pixel_alpha   (pixel_alpha),
		.last_of_line  (last_of_line)
	);

	always begin
		#HALF_NS clk = 1'b1;
		#HALF_NS clk = 1'b0;
	end

	// expander state as the bench sees it: palette, shift of the next pixel,
	// pixels still owed on the open line, and the two registers
	logic [31:0] pal_mem [PAL_ENTRIES];
	logic [2:0]  shift_pos = '0;
	logic [11:0] owed = '0;
	logic [2:0]  fmt = '0;
	logic [23:0] fill = '0;

	pixel_t pending_pixels [$];    // pixels owed by the expander, oldest first

	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;               // no stalls on either side once set
	int tx_quiet = 0;
	int rx_hold = 0;
	int rx_quiet = 0;

	// works out what one accepted word does and queues the pixels it gives
	task automatic expand_word(word_t w);
		int         bpp;
		logic [7:0] mask;
		logic [7:0] v;
		logic [7:0] a;
		logic [31:0] entry;
		pixel_t     px;
		bit         done;
		case (w.op)
			OP_PAL_WR: pal_mem[w.pal_index] = {w.pal_alpha, w.pal_rgb};
			OP_LINE: begin
				// first shift picks the pixel inside the first byte, msb first
				case (fmt[1:0])
					2'd0: shift_pos = 3'd7 - w.phase;
					2'd1: shift_pos = 3'd6 - {w.phase[1:0], 1'b0};
					2'd2: shift_pos = 3'd4 - {w.phase[0], 2'b00};
					default: shift_pos = 3'd0;
				endcase
				owed = w.length;
			end
			OP_DATA: begin
				bpp  = 1 << fmt[1:0];
				mask = 8'((1 << bpp) - 1);
				done = 1'b0;
				// a byte gives pixels until the shift runs out or the line ends;
				// a shift left over from another format is used as it stands
				while (!done && owed != 0) begin
					v = (w.data >> shift_pos) & mask;
					if (fmt[2]) begin
						entry    = pal_mem[v];
						px.color = entry[23:0];
						px.alpha = entry[31:24];
					end else begin
						case (fmt[1:0])
							2'd0: a = (v != 0) ? 8'hFF : 8'h00;
							2'd1: a = v * 8'd85;
							2'd2: a = v * 8'd17;
							default: a = v;
						endcase
						px.color = fill;
						px.alpha = a;
					end
					owed   = owed - 12'd1;
					px.eol = (owed == 0);
					pending_pixels.push_back(px);
					if (shift_pos < bpp) begin
						shift_pos = 3'(8 - bpp);
						done = 1'b1;
					end else begin
						shift_pos = 3'(shift_pos - bpp);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(string msg);
		errors++;
		$display("ERROR cycle %0d: %s", cycles, msg);
	endtask

	// unused fields carry random bits so that every input bit toggles
	function automatic word_t make_word(op_t o);
		word_t w;
		w.op        = o;
		w.pal_index = 8'($urandom);
		w.pal_rgb   = 24'($urandom);
		w.pal_alpha = 8'($urandom);
		w.phase     = 3'($urandom);
		w.length    = 12'($urandom);
		w.data      = 8'($urandom);
		return w;
	endfunction

	function automatic word_t word_pal(logic [7:0] i, logic [23:0] rgb, logic [7:0] a);
		word_t w;
		w           = make_word(OP_PAL_WR);
		w.pal_index = i;
		w.pal_rgb   = rgb;
		w.pal_alpha = a;
		return w;
	endfunction

	function automatic word_t word_line(logic [2:0] ph, logic [11:0] len);
		word_t w;
		w        = make_word(OP_LINE);
		w.phase  = ph;
		w.length = len;
		return w;
	endfunction

	function automatic word_t word_data(logic [7:0] d);
		word_t w;
		w      = make_word(OP_DATA);
		w.data = d;
		return w;
	endfunction

	function automatic stim_row_t row_item(word_t w);
		stim_row_t r;
		r.is_cfg  = 1'b0;
		r.cfg_reg = REG_FORMAT;
		r.cfg_val = '0;
		r.w       = w;
		r.fixed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic stim_row_t row_cfg(logic rsel, logic [31:0] v);
		stim_row_t r;
		r         = row_item(make_word(OP_NONE));
		r.is_cfg  = 1'b1;
		r.cfg_reg = rsel;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic stim_row_t row_pix(word_t w, logic [23:0] c, logic [7:0] a, logic e);
		stim_row_t r;
		r       = row_item(w);
		r.fixed = 1'b1;
		r.want  = {c, a, e};
		return r;
	endfunction

	// offers one word, sometimes after an idle gap,
	// and returns at the edge where it is taken
	task automatic send_word(word_t w);
		int gap;
		gap = 0;
		if (!calm && tx_quiet == 0 && $urandom_range(0, 99) < 15)
			gap = $urandom_range(1, 17);
		if (tx_quiet > 0)
			tx_quiet--;
		else if ($urandom_range(0, 99) < 3)
			tx_quiet = $urandom_range(20, 80);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid    <= 1'b1;
		op            <= w.op;
		palette_index <= w.pal_index;
		palette_rgb   <= w.pal_rgb;
		palette_alpha <= w.pal_alpha;
		start_phase   <= w.phase;
		line_length   <= w.length;
		data_byte     <= w.data;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic issue(word_t w);
		send_word(w);
		expand_word(w);
	endtask

	// stop sending, wait for every owed pixel, then let the pipe empty of
	// words that give nothing
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle; pready is always high
	task automatic cfg_write(logic rsel, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {rsel, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (rsel == REG_FORMAT)
			fmt = v[2:0];
		else
			fill = v[23:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// receiver: random stall bursts, with long quiet stretches
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold     <= rx_hold - 1;
			pixel_ready <= 1'b0;
		end else if (!calm && rx_quiet == 0 && $urandom_range(0, 99) < 10) begin
			rx_hold     <= $urandom_range(0, 16);
			pixel_ready <= 1'b0;
		end else begin
			pixel_ready <= 1'b1;
		end
		if (rx_quiet > 0)
			rx_quiet <= rx_quiet - 1;
		else if ($urandom_range(0, 999) < 5)
			rx_quiet <= $urandom_range(50, 300);
	end

	// pixel checker: every word taken is matched against the oldest owed pixel
	pixel_t head;
	always @(posedge clk) begin
		if (arst_n && pixel_valid && pixel_ready) begin
			if (pending_pixels.size() == 0) begin
				report($sformatf("pixel with none owed: color %h alpha %h last %b",
					pixel_color, pixel_alpha, last_of_line));
			end else begin
				head = pending_pixels.pop_front();
				if (pixel_color !== head.color || pixel_alpha !== head.alpha ||
					last_of_line !== head.eol)
					report($sformatf("pixel got %h/%h/%b, wanted %h/%h/%b",
						pixel_color, pixel_alpha, last_of_line,
						head.color, head.alpha, head.eol));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		stim_row_t directed [$];
		int        depth;
		int        fmt_base;
		int        budget;
		int        pick;
		int        lsel;
		int        nbytes;
		logic [11:0] len;

		// directed table; pixels are typed in only where obvious
		directed = {
			// data with no line open, then the unused op: both silent
			row_item(word_data(8'hFF)),
			row_item(make_word(OP_NONE)),
			// alpha 1 bpp from reset, single pixel line at phase 0
			row_cfg(REG_FILL, 32'h00FFFFFF),
			row_item(word_line(3'd0, 12'd1)),
			row_pix(word_data(8'h80), 24'hFFFFFF, 8'hFF, 1'b1),
			// line starting at the last pixel of a byte, spilling into the next
			row_item(word_line(3'd7, 12'd8)),
			row_item(word_data(8'h01)),
			row_item(word_data(8'hFF)),
			// alpha 2 bpp, last phase in the byte
			row_cfg(REG_FORMAT, 32'd1),
			row_item(word_line(3'd3, 12'd1)),
			row_pix(word_data(8'h02), 24'hFFFFFF, 8'd170, 1'b1),
			// alpha 4 bpp, black fill
			row_cfg(REG_FORMAT, 32'd2),
			row_cfg(REG_FILL, 32'h0),
			row_item(word_line(3'd1, 12'd1)),
			row_pix(word_data(8'h0F), 24'h0, 8'hFF, 1'b1),
			// alpha 8 bpp, phase ignored
			row_cfg(REG_FORMAT, 32'd3),
			row_item(word_line(3'd5, 12'd3)),
			row_item(word_data(8'hAB)),
			row_item(word_data(8'h00)),
			row_item(word_data(8'hFF)),
			// palette entries at both ends
			row_item(word_pal(8'd0, 24'h000000, 8'h00)),
			row_item(word_pal(8'd1, 24'h123456, 8'h5A)),
			row_item(word_pal(8'd255, 24'hFFFFFF, 8'hFF)),
			// indexed 8 bpp
			row_cfg(REG_FORMAT, 32'd7),
			row_item(word_line(3'd0, 12'd2)),
			row_pix(word_data(8'hFF), 24'hFFFFFF, 8'hFF, 1'b0),
			row_pix(word_data(8'h00), 24'h000000, 8'h00, 1'b1),
			// indexed 1 bpp on the longest line
			row_cfg(REG_FORMAT, 32'd4),
			row_item(word_line(3'd6, 12'd4095)),
			row_item(word_data(8'h96)),
			row_item(word_data(8'h3C)),
			// format change with the line still open
			row_cfg(REG_FORMAT, 32'd1),
			row_item(word_data(8'hC3)),
			// empty line, then data that must give nothing
			row_item(word_line(3'd0, 12'd0)),
			row_item(word_data(8'h55))
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				settle();
				cfg_write(directed[i].cfg_reg, directed[i].cfg_val);
			end else begin
				send_word(directed[i].w);
				depth = pending_pixels.size();
				expand_word(directed[i].w);
				if (directed[i].fixed) begin
					while (pending_pixels.size() > depth) void'(pending_pixels.pop_back());
					pending_pixels.push_back(directed[i].want);
				end
			end
		end

		// fill the whole palette so that no indexed read finds an empty entry
		for (int i = 0; i < PAL_ENTRIES; i++)
			issue(word_pal(8'(i), 24'($urandom), 8'($urandom)));

		// random phases, each under its own format; the formats rotate from
		// a random start so all eight are visited, and each phase boundary
		// waits for every owed pixel
		fmt_base = $urandom_range(0, 7);
		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == PHASES - 1)
				calm = 1'b1;
			cfg_write(REG_FORMAT, 32'((p + fmt_base) % 8));
			cfg_write(REG_FILL, (p == 0) ? 32'h00FFFFFF : (p == 1) ? 32'h0 : $urandom);
			budget = PHASE_WORDS;
			while (budget > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 72) begin
					// well-formed line: start, then bytes until the count runs out or twelve
					// bytes are sent, sometimes cut short to three or fewer
					lsel = $urandom_range(0, 99);
					if (lsel < 70)
						len = 12'($urandom_range(1, 24));
					else if (lsel < 90)
						len = 12'($urandom_range(25, 200));
					else
						len = 12'($urandom_range(0, 4095));
					issue(word_line(3'($urandom), len));
					budget--;
					nbytes = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3) : 12;
					while (owed != 0 && nbytes > 0) begin
						issue(word_data(8'($urandom)));
						nbytes--;
						budget--;
					end
				end else if (pick < 84) begin
					issue(word_pal(8'($urandom), 24'($urandom), 8'($urandom)));
					budget--;
				end else if (pick < 90) begin
					issue(make_word(OP_NONE));
				end else if (pick < 95) begin
					// stray byte, lands in an open line or is dropped
					issue(word_data(8'($urandom)));
				end else begin
					// abandoned line start
					issue(word_line(3'($urandom), 12'($urandom)));
					budget--;
				end
			end
		end

		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/ppx_pkg.sv
src/ppx_ram.sv
src/ppx_unpack.sv
src/packed_pixel_palette_expander.sv
bench/tb.sv
